// File: rtl/lzwp_pkg.sv
// Shared types and constants for the LZW code bit packer.
`default_nettype none
package lzwp_pkg;
	localparam int MAX_CODE_BITS = 16;
	localparam int MIN_CODE_BITS = 8;
	localparam int LEFT_W = 7;
	localparam int ACC_W = LEFT_W + MAX_CODE_BITS;
	localparam int CW_W = 5;
	localparam int TOT_W = 5;
	localparam int BMW_W = 4;
	localparam int S_DATA_W = 24;

	localparam logic [1:0] CMD_CODE = 2'd0;
	localparam logic [1:0] CMD_FLUSH = 2'd1;
	localparam logic [1:0] CMD_PAD = 2'd2;

	localparam logic REG_MSB_FIRST = 1'b0;
	localparam logic REG_NO_ALIGN = 1'b1;

	localparam logic [CW_W-1:0] ALIGN_RESET = CW_W'(9);

	typedef struct packed {
		logic load;
		logic step;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic slot_free;
		logic has_byte;
		logic more;
	} stat_t;

	function automatic logic [CW_W-1:0] clamp_width(input logic [CW_W-1:0] w);
		logic [CW_W-1:0] r;
		if (w < CW_W'(MIN_CODE_BITS)) begin
			r = CW_W'(MIN_CODE_BITS);
		end else if (w > CW_W'(MAX_CODE_BITS)) begin
			r = CW_W'(MAX_CODE_BITS);
		end else begin
			r = w;
		end
		return r;
	endfunction
endpackage
`default_nettype wire

// File: rtl/lzwp_ctrl.sv
// Controller state machine for the LZW code bit packer.
`default_nettype none
module lzwp_ctrl
	import lzwp_pkg::*;
(
	input  wire   clk,
	input  wire   arst_n,
	input  wire   in_valid,
	output logic  in_ready,
	input  stat_t stat,
	output cmd_t  cmd
);
	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_RUN = 1'b1;

	logic state_q;
	logic state_n;

	always_comb begin
		in_ready = (state_q == ST_IDLE);
		cmd.load = in_ready && in_valid;
		cmd.step = (state_q == ST_RUN) && stat.slot_free;
		cmd.finish = cmd.step && !(stat.has_byte && stat.more);
		state_n = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_n = ST_RUN;
				end
			end
			ST_RUN: begin
				if (cmd.finish) begin
					state_n = ST_IDLE;
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == ST_RUN)
		else $error("load did not start a run");
	a_no_step_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> !cmd.load)
		else $error("step while loading");
	a_finish_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> in_ready)
		else $error("finish did not return to idle");
endmodule
`default_nettype wire

// File: rtl/lzwp_dpath.sv
// Datapath for the LZW code bit packer: bit accumulator, counters, output register.
`default_nettype none
module lzwp_dpath
	import lzwp_pkg::*;
(
	input  wire                   clk,
	input  wire                   arst_n,
	input  cmd_t                  cmd,
	output stat_t                 stat,
	input  wire  [1:0]            in_cmd,
	input  wire  [MAX_CODE_BITS-1:0] in_code,
	input  wire  [CW_W-1:0]       in_width,
	input  wire                   cfg_wr,
	input  wire                   cfg_idx,
	input  wire                   cfg_val,
	output logic [7:0]            out_byte,
	output logic                  out_last,
	output logic                  out_valid,
	input  wire                   out_ready
);
	logic [1:0]               cmd_q;
	logic [CW_W-1:0]          w_q;
	logic [ACC_W-1:0]         acc_q;
	logic [TOT_W-1:0]         tot_q;
	logic [BMW_W-1:0]         bmw_q;
	logic [CW_W-1:0]          align_q;
	logic                     msb_q;
	logic                     noal_q;
	logic [7:0]               out_q;
	logic                     olast_q;
	logic                     ovalid_q;

	logic [CW_W-1:0]          w_in;
	logic [MAX_CODE_BITS:0]   cmask;
	logic [MAX_CODE_BITS-1:0] codem;
	logic [ACC_W-1:0]         acc_ld;
	logic [TOT_W-1:0]         tot_ld;

	logic                     code_b;
	logic                     flush_b;
	logic                     pad_b;
	logic                     counts;
	logic [ACC_W-1:0]         acc_sh;
	logic [ACC_W-1:0]         acc_n;
	logic [TOT_W-1:0]         tot_n;
	logic [BMW_W-1:0]         bmw_inc;
	logic [BMW_W-1:0]         bmw_n;
	logic [7:0]               byte_n;

	always_comb begin
		w_in = clamp_width(in_width);
		cmask = (MAX_CODE_BITS+1)'(((MAX_CODE_BITS+1)'(1) << w_in) - (MAX_CODE_BITS+1)'(1));
		codem = in_code & cmask[MAX_CODE_BITS-1:0];
		tot_ld = TOT_W'(tot_q[2:0]) + TOT_W'(w_in);
		if (msb_q) begin
			acc_ld = ({{MAX_CODE_BITS{1'b0}}, acc_q[LEFT_W-1:0]} << w_in)
				| {{LEFT_W{1'b0}}, codem};
		end else begin
			acc_ld = {{MAX_CODE_BITS{1'b0}}, acc_q[LEFT_W-1:0]}
				| ({{LEFT_W{1'b0}}, codem} << tot_q[2:0]);
		end
	end

	always_comb begin
		code_b = (tot_q >= TOT_W'(8));
		flush_b = !code_b && (cmd_q == CMD_FLUSH || cmd_q == CMD_PAD) && (tot_q != '0);
		pad_b = !code_b && !flush_b && (cmd_q == CMD_PAD) && (bmw_q != '0);
		counts = ((code_b || flush_b) && !noal_q) || pad_b;
		if (({1'b0, bmw_q} + CW_W'(1)) == align_q) begin
			bmw_inc = '0;
		end else begin
			bmw_inc = bmw_q + BMW_W'(1);
		end
		bmw_n = counts ? bmw_inc : bmw_q;
		acc_n = acc_q;
		tot_n = tot_q;
		byte_n = 8'd0;
		acc_sh = acc_q >> (tot_q - TOT_W'(8));
		priority if (code_b) begin
			tot_n = tot_q - TOT_W'(8);
			if (msb_q) begin
				byte_n = acc_sh[7:0];
				acc_n = acc_q & ACC_W'((ACC_W'(1) << tot_n) - ACC_W'(1));
			end else begin
				byte_n = acc_q[7:0];
				acc_n = acc_q >> 8;
			end
		end else if (flush_b) begin
			tot_n = '0;
			acc_n = '0;
			if (msb_q) begin
				byte_n = acc_q[7:0] << (TOT_W'(8) - tot_q);
			end else begin
				byte_n = acc_q[7:0];
			end
		end else begin
			byte_n = 8'd0;
		end
		stat.slot_free = !ovalid_q || out_ready;
		stat.has_byte = code_b || flush_b || pad_b;
		stat.more = (tot_n >= TOT_W'(8))
			|| ((cmd_q == CMD_FLUSH || cmd_q == CMD_PAD) && tot_n != '0)
			|| (cmd_q == CMD_PAD && bmw_n != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			tot_q <= '0;
			bmw_q <= '0;
			align_q <= ALIGN_RESET;
			msb_q <= 1'b0;
			noal_q <= 1'b0;
			ovalid_q <= 1'b0;
			cmd_q <= CMD_CODE;
			w_q <= ALIGN_RESET;
		end else begin
			if (cfg_wr) begin
				unique case (cfg_idx)
					REG_MSB_FIRST: msb_q <= cfg_val;
					REG_NO_ALIGN:  noal_q <= cfg_val;
					default: ;
				endcase
			end
			if (cmd.load) begin
				cmd_q <= in_cmd;
				w_q <= w_in;
				if (in_cmd == CMD_CODE || in_cmd == CMD_FLUSH) begin
					acc_q <= acc_ld;
					tot_q <= tot_ld;
				end
			end
			if (cmd.step) begin
				acc_q <= acc_n;
				tot_q <= tot_n;
				bmw_q <= bmw_n;
				if (cmd.finish && cmd_q == CMD_PAD) begin
					align_q <= w_q;
				end
			end
			if (cmd.step && stat.has_byte) begin
				ovalid_q <= 1'b1;
			end else if (out_ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step && stat.has_byte) begin
			out_q <= byte_n;
			olast_q <= !stat.more;
		end
	end

	assign out_byte = out_q;
	assign out_last = olast_q;
	assign out_valid = ovalid_q;

	a_bmw_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, bmw_q} < align_q)
		else $error("alignment count out of range");
	a_align_range: assert property (@(posedge clk) disable iff (!arst_n)
		align_q >= CW_W'(MIN_CODE_BITS) && align_q <= CW_W'(MAX_CODE_BITS))
		else $error("alignment width out of range");
	a_load_total: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load && (in_cmd == CMD_CODE || in_cmd == CMD_FLUSH)
		|=> tot_q == TOT_W'($past(tot_q[2:0])) + $past(w_in))
		else $error("bit total wrong after load");
endmodule
`default_nettype wire

// File: rtl/lzw_code_bit_packer.sv
// Top level of the LZW code bit packer.
// Usage:
// - Slave stream carries one command per transaction: tuser holds cmd, tdata holds
//   code and code_width. cmd 0 writes a code, cmd 1 writes a code then flushes the
//   partial byte, cmd 2 flushes, pads zero bytes to the alignment width and then
//   takes code_width as the new alignment width. cmd 3 does nothing.
// - Master stream carries one packed byte per transaction; tlast marks the final
//   byte caused by a command. A command that causes no byte returns nothing.
// - Configuration channel writes msb_first (index 0) and no_alignment (index 1);
//   write it only while the stream is idle.
// A command is taken, then one byte leaves per cycle through the output register
// while the receiver accepts bytes. The next command is accepted once the last
// byte of the previous one is in the output register, while that byte still waits.
// A stalled receiver holds the output register and stops the byte sequencer.
// Reset clears the leftover bits, the alignment count and both config registers,
// and sets the alignment width to 9.
`default_nettype none
module lzw_code_bit_packer
	import lzwp_pkg::*;
(
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 s_tvalid,
	output logic                s_tready,
	input  wire  [S_DATA_W-1:0] s_tdata,  // code[15:0], code_width[20:16], zero pad
	input  wire  [1:0]          s_tuser,  // cmd[1:0]
	output logic                m_tvalid,
	input  wire                 m_tready,
	output logic [7:0]          m_tdata,  // out_byte[7:0]
	output logic                m_tlast,
	input  wire                 cfg_valid,
	output logic                cfg_ready,
	input  wire                 cfg_index,
	input  wire                 cfg_data
);
	cmd_t  cmd;
	stat_t stat;

	assign cfg_ready = 1'b1;

	lzwp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	lzwp_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_cmd    (s_tuser),
		.in_code   (s_tdata[MAX_CODE_BITS-1:0]),
		.in_width  (s_tdata[MAX_CODE_BITS+CW_W-1:MAX_CODE_BITS]),
		.cfg_wr    (cfg_valid),
		.cfg_idx   (cfg_index),
		.cfg_val   (cfg_data),
		.out_byte  (m_tdata),
		.out_last  (m_tlast),
		.out_valid (m_tvalid),
		.out_ready (m_tready)
	);
endmodule
`default_nettype wire
